/* rtl/spdm_pkg.sv */
//------------------------------------------------------------------------------
// spdm_pkg
// Shared types, codes and helper functions for the sorted profile divergence
// merge block.
//------------------------------------------------------------------------------
`default_nettype none

package spdm_pkg;

    localparam int LOG_FRAC = 24;

    localparam logic [1:0] METRIC_JSD     = 2'd0;
    localparam logic [1:0] METRIC_JSDIST  = 2'd1;
    localparam logic [1:0] METRIC_JACCARD = 2'd2;
    localparam logic [1:0] METRIC_BAD     = 2'd3;

    localparam logic REG_METRIC = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MERGE,
        ST_MSB,
        ST_LUT,
        ST_LOG,
        ST_MUL,
        ST_ACC,
        ST_COUNT,
        ST_FIN,
        ST_NORM,
        ST_DIV,
        ST_SQRT,
        ST_WRITE
    } spdm_state_t;

    typedef enum logic [1:0] {
        DEST_P,
        DEST_Q,
        DEST_MIX
    } spdm_dest_t;

    typedef struct packed {
        logic       load;
        logic       latch;
        logic       count;
        logic       clear;
        logic [1:0] job;
        logic       t_msb;
        logic       t_lut;
        logic       t_log;
        logic       t_mul;
        logic       t_acc;
        logic       fin;
        logic       norm;
        logic       div_step;
        logic       sqrt_step;
        logic       last_step;
        logic       emit;
    } spdm_cmd_t;

    typedef struct packed {
        logic can_merge;
        logic last_job;
        logic done;
        logic fin_den_zero;
        logic den_fits;
    } spdm_status_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [LOG_FRAC-1:0] frac_log2(input logic [63:0] y_in);
        logic [63:0]         y;
        logic [LOG_FRAC-1:0] r;
        y = y_in;
        r = '0;
        for (int k = 0; k < LOG_FRAC; k++)
        begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [LOG_FRAC:0] log_tab_entry(input int unsigned i,
                                                        input int unsigned tbits);
        logic [63:0] y;
        y = (64'd1 << 30) + (64'(i) << (30 - tbits));
        if (i == (32'd1 << tbits))
            return (LOG_FRAC+1)'(1) << LOG_FRAC;
        return {1'b0, frac_log2(y)};
    endfunction

endpackage

`default_nettype wire

/* rtl/spdm_ctrl.sv */
//------------------------------------------------------------------------------
// spdm_ctrl
// Sequencer: accepts a record, steps the merge and term pipeline, runs the
// final square root or division iterations and hands the result beat out.
//------------------------------------------------------------------------------
`default_nettype none

module spdm_ctrl
    import spdm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         m_tready,
    output logic              m_tvalid,
    input  wire logic [1:0]   metric,
    input  wire spdm_status_t status,
    output spdm_cmd_t         cmd
);

    spdm_state_t state_reg, state_next;
    logic [1:0]  iter_reg, iter_next;
    logic [1:0]  job_reg, job_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            job_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            iter_reg     <= iter_next;
            job_reg      <= job_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.job    = job_reg;
        s_tready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (iter_reg == 2'd2 || !status.can_merge)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.latch  = 1'b1;
                    job_next   = '0;
                    state_next = metric[1] ? ST_COUNT : ST_MSB;
                end
            end
            ST_COUNT:
            begin
                cmd.count  = 1'b1;
                cmd.clear  = 1'b1;
                iter_next  = iter_reg + 2'd1;
                state_next = ST_MERGE;
            end
            ST_MSB:
            begin
                cmd.t_msb  = 1'b1;
                state_next = ST_LUT;
            end
            ST_LUT:
            begin
                cmd.t_lut  = 1'b1;
                state_next = ST_LOG;
            end
            ST_LOG:
            begin
                cmd.t_log  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.t_mul  = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.t_acc = 1'b1;
                if (status.last_job)
                begin
                    cmd.clear  = 1'b1;
                    iter_next  = iter_reg + 2'd1;
                    state_next = ST_MERGE;
                end
                else
                begin
                    job_next   = job_reg + 2'd1;
                    state_next = ST_MSB;
                end
            end
            ST_FIN:
            begin
                cmd.fin  = 1'b1;
                cnt_next = '0;
                if (status.done && metric == METRIC_JSDIST)
                    state_next = ST_SQRT;
                else if (status.done && metric == METRIC_JACCARD && !status.fin_den_zero)
                    state_next = ST_NORM;
                else
                    state_next = ST_WRITE;
            end
            ST_NORM:
            begin
                if (status.den_fits)
                    state_next = ST_DIV;
                else
                    cmd.norm = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.last_step = (cnt_reg == 5'd31);
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = ST_WRITE;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cmd.last_step = (cnt_reg == 5'd31);
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* rtl/spdm_datapath.sv */
//------------------------------------------------------------------------------
// spdm_datapath
// Head slots, running sums, the staged entropy term unit and the shared
// iteration registers for the final square root and division.
//------------------------------------------------------------------------------
`default_nettype none

module spdm_datapath
    import spdm_pkg::*;
#(
    parameter int KEY_BITS        = 64,
    parameter int VALUE_FRAC_BITS = 32,
    parameter int LOG_TABLE_BITS  = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire spdm_cmd_t    cmd,
    output spdm_status_t      status,
    input  wire logic [1:0]   metric,
    input  wire logic [95:0]  s_tdata,
    input  wire logic         s_tuser,
    input  wire logic         s_tlast,
    output logic [39:0]       m_tdata,
    output logic              m_tuser
);

    localparam int F        = VALUE_FRAC_BITS;
    localparam int XW       = F + 1;
    localparam int NW       = $clog2(XW);
    localparam int TW       = LOG_FRAC + 1;
    localparam int TAB_SIZE = (1 << LOG_TABLE_BITS) + 1;
    localparam int EW       = $clog2(F + 2);
    localparam int LW       = LOG_FRAC + EW + 1;
    localparam int PW       = XW + LW;
    localparam int FRW      = F + LOG_TABLE_BITS + 16;

    logic [TW-1:0] log_tab [TAB_SIZE];

    for (genvar gi = 0; gi < TAB_SIZE; gi++)
    begin : g_tab
        assign log_tab[gi] = log_tab_entry(gi, LOG_TABLE_BITS);
    end

    logic [KEY_BITS-1:0] hpk_reg, hqk_reg;
    logic [F-1:0]        hpv_reg, hqv_reg;
    logic                pf_reg, qf_reg;
    logic [63:0]         sum_p_reg, sum_q_reg, sum_mix_reg;
    logic                take_p_reg, take_q_reg;

    logic [XW-1:0]       x_reg;
    logic [NW-1:0]       n_reg;
    spdm_dest_t          dest_reg;
    logic [TW-1:0]       lo_reg, dlt_reg;
    logic [15:0]         rem_reg;
    logic [LW-1:0]       l_reg;
    logic [PW-1:0]       prod_reg;

    logic [63:0]         acc_reg, res_reg, sbit_reg, den_reg;
    logic [31:0]         dist_reg;
    logic                err_reg;
    logic [39:0]         out_data_reg;
    logic                out_err_reg;

    logic                pv, qv, take_p, take_q, done;
    logic [KEY_BITS-1:0] in_key;
    logic [F-1:0]        in_val;

    assign in_key = s_tdata[KEY_BITS-1:0];
    assign in_val = s_tdata[64+F-1:64];
    assign pv     = (hpv_reg != '0);
    assign qv     = (hqv_reg != '0);
    assign done   = pf_reg && qf_reg && !pv && !qv;

    always_comb
    begin
        if (!pv)
        begin
            take_p = 1'b0;
            take_q = 1'b1;
        end
        else if (!qv)
        begin
            take_p = 1'b1;
            take_q = 1'b0;
        end
        else
        begin
            take_p = !(hpk_reg > hqk_reg);
            take_q = !(hpk_reg < hqk_reg);
        end
    end

    spdm_dest_t    job_dest;
    logic [XW-1:0] job_x;
    logic [NW-1:0] msb_n;

    always_comb
    begin
        if (take_p_reg && take_q_reg)
        begin
            unique case (cmd.job)
                2'd0:
                begin
                    job_dest = DEST_MIX;
                    job_x    = {1'b0, hpv_reg} + {1'b0, hqv_reg};
                end
                2'd1:
                begin
                    job_dest = DEST_P;
                    job_x    = {1'b0, hpv_reg};
                end
                default:
                begin
                    job_dest = DEST_Q;
                    job_x    = {1'b0, hqv_reg};
                end
            endcase
        end
        else if (take_p_reg)
        begin
            job_dest = (cmd.job == 2'd0) ? DEST_P : DEST_MIX;
            job_x    = {1'b0, hpv_reg};
        end
        else
        begin
            job_dest = (cmd.job == 2'd0) ? DEST_Q : DEST_MIX;
            job_x    = {1'b0, hqv_reg};
        end

        msb_n = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (job_x[i])
                msb_n = NW'(i);
        end
    end

    logic [XW-1:0]             x_norm;
    logic [FRW-1:0]            fr;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic [LOG_TABLE_BITS:0]   idx_lo, idx_hi;
    logic [TW-1:0]             lo, hi;
    logic [TW+15:0]            interp_full;
    logic [LW-1:0]             l_val, top;
    logic [63:0]               term_val;

    always_comb
    begin
        x_norm      = x_reg << (NW'(F) - n_reg);
        fr          = {x_norm[F-1:0], {(LOG_TABLE_BITS + 16){1'b0}}};
        idx         = fr[FRW-1 -: LOG_TABLE_BITS];
        idx_lo      = {1'b0, idx};
        idx_hi      = idx_lo + 1'b1;
        lo          = log_tab[idx_lo];
        hi          = log_tab[idx_hi];
        if (hi < lo)
            hi = lo;
        interp_full = dlt_reg * rem_reg;
        l_val       = (LW'(n_reg) << LOG_FRAC) + LW'(lo_reg) + LW'(interp_full[TW+15:16]);
        top         = (dest_reg == DEST_MIX) ? (LW'(F + 1) << LOG_FRAC) : (LW'(F) << LOG_FRAC);
        term_val    = 64'(prod_reg >> F);
    end

    logic [63:0] fin_a, fin_diff, fin_num, fin_den;
    logic [31:0] fin_q31;

    always_comb
    begin
        fin_a    = sat_add64(sum_p_reg, sum_q_reg);
        fin_diff = sum_mix_reg - fin_a;
        if (sum_mix_reg <= fin_a)
            fin_q31 = '0;
        else if (fin_diff > 64'h0000_0000_03FF_FFFF)
            fin_q31 = 32'hFFFF_FFFF;
        else
            fin_q31 = {fin_diff[25:0], 6'b0};
        fin_num = fin_a;
        fin_den = sat_add64(fin_a, sum_mix_reg);
    end

    logic [63:0] trial, acc_step, res_step, sbit_step;

    always_comb
    begin
        trial     = res_reg + sbit_reg;
        sbit_step = sbit_reg >> 2;
        if (cmd.sqrt_step)
        begin
            if (acc_reg >= trial)
            begin
                acc_step = acc_reg - trial;
                res_step = (res_reg >> 1) + sbit_reg;
            end
            else
            begin
                acc_step = acc_reg;
                res_step = res_reg >> 1;
            end
        end
        else
        begin
            if (acc_reg >= den_reg)
            begin
                acc_step = (acc_reg - den_reg) << 1;
                res_step = {res_reg[62:0], 1'b1};
            end
            else
            begin
                acc_step = acc_reg << 1;
                res_step = {res_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpk_reg     <= '0;
            hqk_reg     <= '0;
            hpv_reg     <= '0;
            hqv_reg     <= '0;
            pf_reg      <= 1'b0;
            qf_reg      <= 1'b0;
            sum_p_reg   <= '0;
            sum_q_reg   <= '0;
            sum_mix_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (!s_tuser && !pv && !pf_reg)
                begin
                    if (in_val != '0)
                    begin
                        hpk_reg <= in_key;
                        hpv_reg <= in_val;
                    end
                    if (s_tlast)
                        pf_reg <= 1'b1;
                end
                if (s_tuser && !qv && !qf_reg)
                begin
                    if (in_val != '0)
                    begin
                        hqk_reg <= in_key;
                        hqv_reg <= in_val;
                    end
                    if (s_tlast)
                        qf_reg <= 1'b1;
                end
            end
            if (cmd.count && metric == METRIC_JACCARD)
            begin
                if (take_p_reg && take_q_reg)
                    sum_mix_reg <= sat_add64(sum_mix_reg, 64'd1);
                else if (take_p_reg)
                    sum_p_reg <= sat_add64(sum_p_reg, 64'd1);
                else
                    sum_q_reg <= sat_add64(sum_q_reg, 64'd1);
            end
            if (cmd.t_acc)
            begin
                unique case (dest_reg)
                    DEST_P:   sum_p_reg   <= sat_add64(sum_p_reg, term_val);
                    DEST_Q:   sum_q_reg   <= sat_add64(sum_q_reg, term_val);
                    default:  sum_mix_reg <= sat_add64(sum_mix_reg, term_val);
                endcase
            end
            if (cmd.clear)
            begin
                if (take_p_reg)
                    hpv_reg <= '0;
                if (take_q_reg)
                    hqv_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            take_p_reg <= take_p;
            take_q_reg <= take_q;
        end
        if (cmd.t_msb)
        begin
            x_reg    <= job_x;
            n_reg    <= msb_n;
            dest_reg <= job_dest;
        end
        if (cmd.t_lut)
        begin
            lo_reg  <= lo;
            dlt_reg <= hi - lo;
            rem_reg <= fr[FRW-1-LOG_TABLE_BITS -: 16];
        end
        if (cmd.t_log)
            l_reg <= l_val;
        if (cmd.t_mul)
        begin
            if (l_reg >= top)
                prod_reg <= '0;
            else
                prod_reg <= PW'(x_reg) * PW'(top - l_reg);
        end
        if (cmd.fin)
        begin
            dist_reg <= (done && metric == METRIC_JSD) ? fin_q31 : 32'd0;
            err_reg  <= (metric == METRIC_BAD) ||
                        (done && metric == METRIC_JACCARD && fin_den == '0);
            acc_reg  <= (metric == METRIC_JACCARD) ? fin_num : {1'b0, fin_q31, 31'b0};
            res_reg  <= '0;
            sbit_reg <= 64'd1 << 62;
            den_reg  <= fin_den;
        end
        if (cmd.norm)
        begin
            den_reg <= den_reg >> 1;
            acc_reg <= acc_reg >> 1;
        end
        if (cmd.div_step || cmd.sqrt_step)
        begin
            acc_reg  <= acc_step;
            res_reg  <= res_step;
            sbit_reg <= sbit_step;
            if (cmd.last_step)
                dist_reg <= res_step[31:0];
        end
        if (cmd.emit)
        begin
            out_data_reg <= {5'b0, dist_reg, done,
                             !done && !qv && !qf_reg, !done && !pv && !pf_reg};
            out_err_reg  <= err_reg;
        end
    end

    always_comb
    begin
        status.can_merge    = (pv || pf_reg) && (qv || qf_reg) && (pv || qv);
        status.last_job     = (cmd.job == 2'd2) || (cmd.job == 2'd1 && !(take_p_reg && take_q_reg));
        status.done         = done;
        status.fin_den_zero = (fin_den == '0);
        status.den_fits     = (den_reg[63:32] == '0);
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_err_reg;

endmodule

`default_nettype wire

/* rtl/sorted_profile_divergence_merge.sv */
//------------------------------------------------------------------------------
// sorted_profile_divergence_merge
// Merge-join of two key-sorted profiles into a JS divergence, JS distance or
// Jaccard distance, with one result beat per record beat.
//
//   Channel | Role        | Contents
//   s_*     | record in   | tdata: record_key[63:0], record_value[95:64];
//           |             | tuser: side; tlast: last_record
//   m_*     | result out  | tdata: need_p, need_q, done_res, distance[34:3];
//           |             | tuser: error
//   APB     | config      | register 0 at byte address 0: metric[1:0]
//
// A record is accepted in the idle state and then passes up to two merges. Each
// merge is a decision state plus the MSB, LUT, LOG, MUL and ACC states per
// entropy term (two terms, or three when both heads hold the same key), or a
// count state in Jaccard mode. A closing decision, a finish and a write state
// follow. JS distance adds 32 square root steps; Jaccard adds normalizing
// shifts and 32 division steps.
// Reset clears heads, flags, sums and metric at once. A stalled result beat
// holds in the output register; the next record waits for the write slot.
//------------------------------------------------------------------------------
`default_nettype none

module sorted_profile_divergence_merge
    import spdm_pkg::*;
#(
    parameter int KEY_BITS        = 64,
    parameter int VALUE_FRAC_BITS = 32,
    parameter int LOG_TABLE_BITS  = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // record_key[63:0], record_value[95:64]
    input  wire logic        s_tuser,   // side
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // need_p, need_q, done_res, distance[34:3]
    output logic             m_tuser,   // error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [1:0]   metric_reg;
    spdm_cmd_t    cmd;
    spdm_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            metric_reg <= METRIC_JSD;
        else if (psel && penable && pwrite && paddr[2] == REG_METRIC)
            metric_reg <= pwdata[1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_METRIC) ? {30'b0, metric_reg} : 32'd0;

    spdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .metric   (metric_reg),
        .status   (status),
        .cmd      (cmd)
    );

    spdm_datapath #(
        .KEY_BITS        (KEY_BITS),
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
        .LOG_TABLE_BITS  (LOG_TABLE_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .metric  (metric_reg),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire
